/* src/assert_macros.svh */
// Assertion macros for the RTL files; included by mmpd_bin_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mmpd_pkg.sv */
// ----------------------------------------------------------------------------
// mmpd_pkg
// Types and constants of the min/max peak-detect decimator.
// ----------------------------------------------------------------------------
package mmpd_pkg;

    localparam int SAMPLE_W         = 32;
    localparam int IDX_W            = 16;
    localparam int SCALE_W          = 32;
    localparam int FRAC_W           = 16;
    localparam int ACC_W            = SCALE_W + 1;
    localparam int MMPD_MAX_SAMPLES = 65536;

    // Bin scales below 2.0 in Q16.16 select pass-through.
    localparam logic [SCALE_W-1:0] PASS_LIMIT       = SCALE_W'(32'h0002_0000);
    localparam logic [SCALE_W-1:0] BIN_SCALE_RESET  = SCALE_W'(32'h0001_0000);
    localparam logic [IDX_W-1:0]   LAST_INDEX_RESET = IDX_W'(1);

    typedef enum logic [0:0] {
        REG_BIN_SCALE  = 1'b0,
        REG_LAST_INDEX = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [SCALE_W-1:0] bin_scale;
        logic [IDX_W-1:0]   last_index;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] point_x;
        logic signed [SAMPLE_W-1:0] low_y;
        logic signed [SAMPLE_W-1:0] high_y;
        logic                       is_final;
    } result_t;

endpackage

/* src/mmpd_if.sv */
// ----------------------------------------------------------------------------
// mmpd_if
// Valid/ready channels of the decimator: samples, points and configuration.
// ----------------------------------------------------------------------------
interface sample_if;
    import mmpd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;

    modport source (output valid, output sample_x, output sample_y, input ready);
    modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface point_if;
    import mmpd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] point_x;
    logic signed [SAMPLE_W-1:0] low_y;
    logic signed [SAMPLE_W-1:0] high_y;
    logic                       is_final;

    modport source (output valid, output point_x, output low_y, output high_y,
                    output is_final, input ready);
    modport sink   (input valid, input point_x, input low_y, input high_y,
                    input is_final, output ready);
endinterface

interface cfg_if;
    import mmpd_pkg::*;

    logic               valid;
    logic               ready;
    reg_idx_t           index;
    logic [SCALE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/minmax_peak_decimator.sv */
// ----------------------------------------------------------------------------
// minmax_peak_decimator
// Min/max peak-detect decimation of one trace: one point per bin, or every
// sample as a point when the bin scale is below 2.0.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload                                Item
// samples   in    sample_x, sample_y                     one trace sample
// points    out   point_x, low_y, high_y, is_final       one bin or sample point
// cfg       in    index, data                            one register write
//
// One sample is taken every cycle while the point sink keeps up; an accepted
// sample is held in the input register, and its result goes to the output register.
// Reset puts all state but the held sample and point data at its start values at once; there is no clearing pass.
// A stalled point sink holds the output register; the input register then
// holds, and samples are taken again as soon as the point is taken.
// ----------------------------------------------------------------------------
module minmax_peak_decimator #(
    parameter int MAX_SAMPLES = mmpd_pkg::MMPD_MAX_SAMPLES
) (
    input  logic    clk,
    input  logic    rst_n,
    sample_if.sink  samples,
    point_if.source points,
    cfg_if.sink     cfg
);
    import mmpd_pkg::*;

    cfg_t    regs;
    sample_t item;
    logic    item_valid;
    logic    item_take;
    logic    room;
    logic    res_valid;
    result_t res;

    mmpd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mmpd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    mmpd_bin_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .room       (room),
        .res_valid  (res_valid),
        .res        (res)
    );

    mmpd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .points    (points)
    );

endmodule

/* src/mmpd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mmpd_cfg_regs
// Configuration registers: bin scale and last sample index.
// ----------------------------------------------------------------------------
module mmpd_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    cfg_if.sink           cfg,
    output mmpd_pkg::cfg_t regs
);
    import mmpd_pkg::*;

    logic [SCALE_W-1:0] bin_scale_reg;
    logic [IDX_W-1:0]   last_index_reg;

    assign cfg.ready = 1'b1;
    assign regs.bin_scale  = bin_scale_reg;
    assign regs.last_index = last_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_scale_reg  <= BIN_SCALE_RESET;
            last_index_reg <= LAST_INDEX_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BIN_SCALE:  bin_scale_reg  <= cfg.data;
                REG_LAST_INDEX: last_index_reg <= cfg.data[IDX_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

/* src/mmpd_in_reg.sv */
// ----------------------------------------------------------------------------
// mmpd_in_reg
// Input register: holds one sample item until the bin logic takes it.
// ----------------------------------------------------------------------------
module mmpd_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    sample_if.sink            samples,
    output mmpd_pkg::sample_t item,
    output logic              item_valid,
    input  logic              item_take
);
    import mmpd_pkg::*;

    logic    valid_reg;
    sample_t item_reg;

    // A new item may enter while the held one is taken in the same cycle.
    assign samples.ready = !valid_reg || item_take;
    assign item          = item_reg;
    assign item_valid    = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            item_reg.sample_x <= samples.sample_x;
            item_reg.sample_y <= samples.sample_y;
        end
    end

endmodule

/* src/mmpd_bin_core.sv */
// ----------------------------------------------------------------------------
// mmpd_bin_core
// Bin state and the single-pass update: pass-through, running min/max,
// middle sample capture and accumulator advance at each bin boundary.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmpd_bin_core #(
    parameter int MAX_SAMPLES = mmpd_pkg::MMPD_MAX_SAMPLES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mmpd_pkg::cfg_t    regs,
    input  mmpd_pkg::sample_t item,
    input  logic              item_valid,
    output logic              item_take,
    input  logic              room,
    output logic              res_valid,
    output mmpd_pkg::result_t res
);
    import mmpd_pkg::*;

    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam logic [IDX_W-1:0] LAST_CAP =
        (MAX_SAMPLES - 1 > IDX_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(MAX_SAMPLES - 1);

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [SCALE_W-1:0] scale);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + (ACC_W + 1)'(scale);
        return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] bin_limit(input logic [ACC_W-1:0] acc,
                                                   input logic [IDX_W-1:0] last);
        logic [ACC_W-FRAC_W-1:0] whole;
        whole = acc[ACC_W-1:FRAC_W];
        return (whole < (ACC_W - FRAC_W)'(last)) ? whole[IDX_W-1:0] : last;
    endfunction

    logic [IDX_W-1:0]           sample_index_reg, sample_index_next;
    logic [ACC_W-1:0]           step_accum_reg, step_accum_next;
    logic [IDX_W-1:0]           bin_end_reg, bin_end_next;
    logic [IDX_W-1:0]           mid_index_reg, mid_index_next;
    logic signed [SAMPLE_W-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_W-1:0] run_max_reg, run_max_next;
    logic signed [SAMPLE_W-1:0] mid_x_reg, mid_x_next;
    logic                       finished_reg, finished_next;

    logic [IDX_W-1:0]           eff_last;
    logic                       first;
    logic                       pass;
    logic                       fin;
    logic [ACC_W-1:0]           acc_cur;
    logic [IDX_W-1:0]           end_cur;
    logic [IDX_W-1:0]           mid_cur;
    logic signed [SAMPLE_W-1:0] min_cur;
    logic signed [SAMPLE_W-1:0] max_cur;
    logic signed [SAMPLE_W-1:0] midx_cur;
    logic [ACC_W-1:0]           acc_new;
    logic [IDX_W-1:0]           end_new;
    logic [IDX_W:0]             mid_sum;
    logic [IDX_W-1:0]           mid_new;

    assign item_take = item_valid && room;

    assign eff_last = (regs.last_index < LAST_CAP) ? regs.last_index : LAST_CAP;
    assign first    = (sample_index_reg == '0);
    assign pass     = (regs.bin_scale < PASS_LIMIT);
    assign fin      = (sample_index_reg >= eff_last);

    // The first sample of the run opens the first bin from the live scale.
    assign acc_cur = first ? ACC_W'(regs.bin_scale) : step_accum_reg;
    assign end_cur = first ? bin_limit(acc_cur, eff_last) : bin_end_reg;
    assign mid_cur = first ? (end_cur >> 1) : mid_index_reg;
    assign min_cur = (first || item.sample_y < run_min_reg) ? item.sample_y : run_min_reg;
    assign max_cur = (first || item.sample_y > run_max_reg) ? item.sample_y : run_max_reg;
    assign midx_cur = (sample_index_reg == mid_cur) ? item.sample_x : mid_x_reg;

    // Next bin, opened on the boundary sample itself.
    assign acc_new = sat_add(acc_cur, regs.bin_scale);
    assign end_new = bin_limit(acc_new, eff_last);
    assign mid_sum = (IDX_W + 1)'(sample_index_reg) + (IDX_W + 1)'(end_new);
    assign mid_new = mid_sum[IDX_W:1];

    always_comb
    begin
        sample_index_next = sample_index_reg;
        step_accum_next   = step_accum_reg;
        bin_end_next      = bin_end_reg;
        mid_index_next    = mid_index_reg;
        run_min_next      = run_min_reg;
        run_max_next      = run_max_reg;
        mid_x_next        = mid_x_reg;
        finished_next     = finished_reg;
        res_valid         = 1'b0;
        res.point_x       = item.sample_x;
        res.low_y         = item.sample_y;
        res.high_y        = item.sample_y;
        res.is_final      = fin;

        if (item_take && !finished_reg)
        begin
            if (pass)
            begin
                res_valid = 1'b1;
                if (fin)
                    finished_next = 1'b1;
                else
                    sample_index_next = sample_index_reg + 1'b1;
            end
            else
            begin
                step_accum_next = acc_cur;
                bin_end_next    = end_cur;
                mid_index_next  = mid_cur;
                run_min_next    = min_cur;
                run_max_next    = max_cur;
                mid_x_next      = midx_cur;
                if (!fin && sample_index_reg < end_cur)
                begin
                    sample_index_next = sample_index_reg + 1'b1;
                end
                else
                begin
                    res_valid   = 1'b1;
                    res.point_x = midx_cur;
                    res.low_y   = min_cur;
                    res.high_y  = max_cur;
                    if (fin)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        step_accum_next   = acc_new;
                        bin_end_next      = end_new;
                        mid_index_next    = mid_new;
                        run_min_next      = item.sample_y;
                        run_max_next      = item.sample_y;
                        if (mid_new == sample_index_reg)
                            mid_x_next = item.sample_x;
                        sample_index_next = sample_index_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            step_accum_reg   <= '0;
            bin_end_reg      <= IDX_W'(1);
            mid_index_reg    <= '0;
            run_min_reg      <= '0;
            run_max_reg      <= '0;
            mid_x_reg        <= '0;
            finished_reg     <= 1'b0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            step_accum_reg   <= step_accum_next;
            bin_end_reg      <= bin_end_next;
            mid_index_reg    <= mid_index_next;
            run_min_reg      <= run_min_next;
            run_max_reg      <= run_max_next;
            mid_x_reg        <= mid_x_next;
            finished_reg     <= finished_next;
        end
    end

    `ASSERT_CLK(a_no_result_after_end, clk, rst_n, finished_reg |-> !res_valid, "result after run end")
    `ASSERT_CLK(a_final_ends_run, clk, rst_n, (res_valid && res.is_final) |=> finished_reg, "final result did not end the run")
    `ASSERT_CLK(a_index_advances, clk, rst_n, (res_valid && !res.is_final) |=> (sample_index_reg == $past(sample_index_reg) + 1'b1), "index did not advance after a result")

endmodule

/* src/mmpd_out_reg.sv */
// ----------------------------------------------------------------------------
// mmpd_out_reg
// Output register: holds one point item until the sink takes it.
// ----------------------------------------------------------------------------
module mmpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  mmpd_pkg::result_t res,
    output logic              room,
    point_if.source           points
);
    import mmpd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign room            = !valid_reg || points.ready;
    assign points.valid    = valid_reg;
    assign points.point_x  = res_reg.point_x;
    assign points.low_y    = res_reg.low_y;
    assign points.high_y   = res_reg.high_y;
    assign points.is_final = res_reg.is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
